// ===== hdl/fnvh_pkg.sv =====
// Shared types and constants for the FNV-1a chained hash table unit.
package fnvh_pkg;

  localparam int unsigned BUCKETS       = 256;
  localparam int unsigned POOL_ENTRIES  = 256;
  localparam int unsigned MAX_KEY_BYTES = 8;

  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned IDX_W   = $clog2(POOL_ENTRIES);
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned BCFG_W  = 9;
  localparam int unsigned SCAN_W  = 16;
  localparam int unsigned SCAN_N  = POOL_ENTRIES / SCAN_W;
  localparam int unsigned SCAN_CW = $clog2(SCAN_N) + 1;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME_L = 64'h1b3;   // prime is 2^40 + 0x1b3
  localparam int unsigned FNV_SHIFT   = 40;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_REM = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NFOUND  = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_HEAD, S_CHK, S_WALK, S_ACT, S_INS, S_REMP, S_REMN, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    HP_IDLE, HP_MIX, HP_MOD
  } hphase_e;

  typedef struct packed {
    logic [63:0]      key;
    logic [3:0]       klen;
    logic [63:0]      hash;
    logic [63:0]      value;
    logic [IDX_W-1:0] next;
    logic             nv;
    logic [IDX_W-1:0] prev;
    logic             pv;
  } slot_t;

  typedef struct packed {
    logic             done;
    logic [63:0]      hash;
    logic [BKT_W-1:0] bucket;
  } hash_res_t;

endpackage

// ===== hdl/fnvh_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module fnvh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fnvh_hash.sv =====
// Iterative FNV-1a hash, one byte per cycle, then hash mod bucket count, four bits per cycle.
module fnvh_hash import fnvh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       key_i,
  input  logic [3:0]        len_i,
  input  logic [BCFG_W-1:0] bucket_count_i,
  output hash_res_t         res_o
);

  hphase_e          ph_q, ph_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [63:0]      h_q, h_d;
  logic [63:0]      kb_q, kb_d;
  logic [63:0]      m_q, m_d;
  logic [BKT_W-1:0] r_q, r_d;
  logic [BCFG_W-1:0] n_q, n_d;

  logic [63:0]      mix_x, mix_h;
  logic [BKT_W:0]   t;
  logic [BKT_W-1:0] r;
  logic [BCFG_W-1:0] n_clamp;

  always_comb begin
    n_clamp = bucket_count_i;
    if (bucket_count_i == '0) n_clamp = BCFG_W'(1);
    if (bucket_count_i > BCFG_W'(BUCKETS)) n_clamp = BCFG_W'(BUCKETS);
  end

  assign mix_x = h_q ^ {56'd0, kb_q[7:0]};
  assign mix_h = (mix_x << FNV_SHIFT) + mix_x * FNV_PRIME_L;

  // remainder, MSB first, four restoring steps
  always_comb begin
    r = r_q;
    t = '0;
    for (int k = 0; k < 4; k++) begin
      t = {r, m_q[63-k]};
      if (t >= (BKT_W+1)'(n_q)) t = t - (BKT_W+1)'(n_q);
      r = t[BKT_W-1:0];
    end
  end

  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    h_d    = h_q;
    kb_d   = kb_q;
    m_d    = m_q;
    r_d    = r_q;
    n_d    = n_q;
    if (start_i) begin
      done_d = 1'b0;
      h_d    = FNV_BASIS;
      kb_d   = key_i;
      n_d    = n_clamp;
      r_d    = '0;
      m_d    = FNV_BASIS;
      if (len_i == '0) begin
        ph_d  = HP_MOD;
        cnt_d = 4'd15;
      end else begin
        ph_d  = HP_MIX;
        cnt_d = len_i;
      end
    end else begin
      unique case (ph_q)
        HP_MIX: begin
          h_d  = mix_h;
          kb_d = kb_q >> 8;
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            ph_d  = HP_MOD;
            m_d   = mix_h;
            cnt_d = 4'd15;
          end
        end
        HP_MOD: begin
          r_d   = r;
          m_d   = m_q << 4;
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == '0) begin
            ph_d   = HP_IDLE;
            done_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= HP_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q  <= h_d;
    kb_q <= kb_d;
    m_q  <= m_d;
    r_q  <= r_d;
    n_q  <= n_d;
  end

  assign res_o.done   = done_q;
  assign res_o.hash   = h_q;
  assign res_o.bucket = r_q;

endmodule

// ===== hdl/fnv1a_chained_hash_table_unit.sv =====
// Each item is hashed, its bucket head is read and its chain walked entry by entry, then any
// link updates in neighbouring entries follow before the result goes valid.
// One item in flight; a new beat is taken in the cycle the result goes valid, and not before.
// A result beat that waits holds the next item in its last state.
// Reset: asynchronous, clears bucket valid bits, slot used bits and the entry count at once;
// no clearing pass. Bucket count resets to 256.
module fnv1a_chained_hash_table_unit import fnvh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BCFG_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [63:0]       key_bytes_i,
  input  logic [3:0]        key_length_i,
  input  logic [63:0]       new_value_i,
  input  logic              allow_insert_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [63:0]       read_value_o,
  output logic [CNT_W-1:0]  stored_count_o
);

  state_e state_q, state_d;
  logic [BCFG_W-1:0] bc_q;
  op_e         op_q;
  logic [63:0] key_q, val_q;
  logic [3:0]  len_q;
  logic        allow_q;

  logic [POOL_ENTRIES-1:0] used_q;
  logic [BUCKETS-1:0]      hv_q;
  logic [CNT_W-1:0]        cnt_q;

  logic [IDX_W-1:0] cur_q, head_idx_q, free_idx_q;
  logic             head_v_q, hit_q, free_ok_q;
  slot_t            ent_q;
  logic [SCAN_CW-1:0] scan_q;

  status_e     status_q;
  logic [63:0] rd_q;
  logic [CNT_W-1:0] ocnt_q;
  logic        outv_q;

  status_e     res_status;
  logic [63:0] res_rd;

  logic accept, match;
  logic [3:0]  len_c;
  logic [63:0] key_c;
  hash_res_t   hres;

  logic             s_we, s_re, h_we, h_re;
  logic [IDX_W-1:0] s_waddr, s_raddr;
  slot_t            s_wdata, s_rd;
  logic [BKT_W-1:0] h_raddr;
  logic [IDX_W-1:0] h_wdata, h_rd;

  logic [SCAN_W-1:0]         chunk;
  logic [$clog2(SCAN_W)-1:0] enc;
  logic                      enc_ok;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    len_c = (key_length_i > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length_i;
    for (int i = 0; i < 8; i++) begin
      key_c[i*8 +: 8] = (4'(i) < len_c) ? key_bytes_i[i*8 +: 8] : 8'd0;
    end
  end

  fnvh_hash u_hash (
    .clk_i,
    .rst_ni,
    .start_i        (accept),
    .key_i          (key_c),
    .len_i          (len_c),
    .bucket_count_i (bc_q),
    .res_o          (hres)
  );

  fnvh_ram #(.Width($bits(slot_t)), .Depth(POOL_ENTRIES)) u_slot_ram (
    .clk_i,
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rd)
  );

  fnvh_ram #(.Width(IDX_W), .Depth(BUCKETS)) u_head_ram (
    .clk_i,
    .we_i    (h_we),
    .waddr_i (hres.bucket),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rd)
  );

  assign match = (s_rd.klen == len_q) && (s_rd.hash == hres.hash) && (s_rd.key == key_q);

  // lowest free slot, one group of used bits per cycle while the hash runs
  always_comb begin
    chunk  = used_q[scan_q[SCAN_CW-2:0]*SCAN_W +: SCAN_W];
    enc    = '0;
    enc_ok = 1'b0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        enc    = ($clog2(SCAN_W))'(i);
        enc_ok = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    s_we    = 1'b0;
    s_waddr = cur_q;
    s_wdata = ent_q;
    s_re    = 1'b0;
    s_raddr = cur_q;
    h_we    = 1'b0;
    h_wdata = free_idx_q;
    h_re    = 1'b0;
    h_raddr = hres.bucket;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_HASH;
      S_HASH: if (hres.done) begin
        h_re    = 1'b1;
        state_d = S_HEAD;
      end
      S_HEAD: state_d = S_CHK;
      S_CHK: begin
        if (hv_q[hres.bucket]) begin
          s_re    = 1'b1;
          s_raddr = h_rd;
          state_d = S_WALK;
        end else begin
          state_d = S_ACT;
        end
      end
      S_WALK: begin
        if (match) begin
          state_d = S_ACT;
        end else if (s_rd.nv) begin
          s_re    = 1'b1;
          s_raddr = s_rd.next;
        end else begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_DONE;
        case (op_q)
          OP_SET: begin
            if (hit_q) begin
              s_we          = 1'b1;
              s_wdata.value = val_q;
            end else if (allow_q && free_ok_q) begin
              s_we    = 1'b1;
              s_waddr = free_idx_q;
              s_wdata = '{key: key_q, klen: len_q, hash: hres.hash, value: val_q,
                          next: head_idx_q, nv: head_v_q, prev: '0, pv: 1'b0};
              h_we    = 1'b1;
              if (head_v_q) begin
                s_re    = 1'b1;
                s_raddr = head_idx_q;
                state_d = S_INS;
              end
            end
          end
          OP_REM: begin
            if (hit_q) begin
              if (ent_q.pv) begin
                s_re    = 1'b1;
                s_raddr = ent_q.prev;
                state_d = S_REMP;
              end else begin
                h_we    = 1'b1;
                h_wdata = ent_q.next;
                if (ent_q.nv) begin
                  s_re    = 1'b1;
                  s_raddr = ent_q.next;
                  state_d = S_REMN;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_INS: begin
        s_we       = 1'b1;
        s_waddr    = head_idx_q;
        s_wdata    = s_rd;
        s_wdata.prev = free_idx_q;
        s_wdata.pv = 1'b1;
        state_d    = S_DONE;
      end
      S_REMP: begin
        s_we       = 1'b1;
        s_waddr    = ent_q.prev;
        s_wdata    = s_rd;
        s_wdata.next = ent_q.next;
        s_wdata.nv = ent_q.nv;
        state_d    = S_DONE;
        if (ent_q.nv) begin
          s_re    = 1'b1;
          s_raddr = ent_q.next;
          state_d = S_REMN;
        end
      end
      S_REMN: begin
        s_we       = 1'b1;
        s_waddr    = ent_q.next;
        s_wdata    = s_rd;
        s_wdata.prev = ent_q.prev;
        s_wdata.pv = ent_q.pv;
        state_d    = S_DONE;
      end
      S_DONE: if (!outv_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result fields; hit, entry and free-slot flags stay put until the next accept
  always_comb begin
    res_status = ST_NFOUND;
    res_rd     = '0;
    case (op_q)
      OP_SET: begin
        if (hit_q || (allow_q && free_ok_q)) res_status = ST_OK;
        else if (allow_q) res_status = ST_NOSPACE;
      end
      OP_GET: if (hit_q) begin
        res_status = ST_OK;
        res_rd     = ent_q.value;
      end
      OP_REM: if (hit_q) res_status = ST_OK;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bc_q      <= BCFG_W'(BUCKETS);
      used_q    <= '0;
      hv_q      <= '0;
      cnt_q     <= '0;
      outv_q    <= 1'b0;
      scan_q    <= SCAN_CW'(SCAN_N);
      free_ok_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) bc_q <= cfg_wdata_i;
      if (state_q == S_DONE && (!outv_q || out_ready_i)) outv_q <= 1'b1;
      else if (outv_q && out_ready_i) outv_q <= 1'b0;
      if (accept) begin
        scan_q    <= '0;
        free_ok_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (!scan_q[SCAN_CW-1]) begin
        scan_q <= scan_q + SCAN_CW'(1);
        if (!free_ok_q && enc_ok) begin
          free_ok_q  <= 1'b1;
        end
      end
      if (state_q == S_WALK && match) hit_q <= 1'b1;
      if (state_q == S_ACT) begin
        if (op_q == OP_SET && !hit_q && allow_q && free_ok_q) begin
          used_q[free_idx_q]  <= 1'b1;
          hv_q[hres.bucket]   <= 1'b1;
          cnt_q               <= cnt_q + CNT_W'(1);
        end
        if (op_q == OP_REM && hit_q) begin
          used_q[cur_q] <= 1'b0;
          if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
          if (!ent_q.pv) hv_q[hres.bucket] <= ent_q.nv;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(operation_i);
      key_q   <= key_c;
      len_q   <= len_c;
      val_q   <= new_value_i;
      allow_q <= allow_insert_i;
    end
    if (!accept && !scan_q[SCAN_CW-1] && !free_ok_q && enc_ok) begin
      free_idx_q <= IDX_W'({scan_q[SCAN_CW-2:0], enc});
    end
    if (state_q == S_CHK) begin
      head_idx_q <= h_rd;
      head_v_q   <= hv_q[hres.bucket];
      cur_q      <= h_rd;
    end
    if (state_q == S_WALK) begin
      ent_q <= s_rd;
      if (!match) cur_q <= s_rd.next;
    end
    // result beat is loaded only once the previous one has left
    if (state_q == S_DONE && (!outv_q || out_ready_i)) begin
      status_q <= res_status;
      rd_q     <= res_rd;
      ocnt_q   <= cnt_q;
    end
  end

  assign out_valid_o    = outv_q;
  assign status_o       = status_q;
  assign read_value_o   = rd_q;
  assign stored_count_o = ocnt_q;

`ifndef SYNTHESIS
  a_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(cnt_q))
    else $error("entry count differs from used slots");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("accepted a beat while busy");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= POOL_ENTRIES)
    else $error("entry count above pool size");
`endif

endmodule

// ===== test/tb_fnv1a_chained_hash_table_unit.sv =====
// Self-checking testbench for the FNV-1a chained hash table unit.
`timescale 1ns / 100ps

module tb_fnv1a_chained_hash_table_unit;
  import fnvh_pkg::*;

  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned DRAIN_WAIT  = 40;

  class hash_table_scoreboard;
    logic [BCFG_W-1:0] bucket_cfg;
    bit               head_v[BUCKETS];
    bit [IDX_W-1:0]   head[BUCKETS];
    bit               used[POOL_ENTRIES];
    bit [63:0]        skey[POOL_ENTRIES];
    bit [3:0]         slen[POOL_ENTRIES];
    bit [63:0]        shash[POOL_ENTRIES];
    bit [63:0]        sval[POOL_ENTRIES];
    bit [IDX_W-1:0]   nxt[POOL_ENTRIES];
    bit               nv[POOL_ENTRIES];
    bit [IDX_W-1:0]   prv[POOL_ENTRIES];
    bit               pv[POOL_ENTRIES];
    int unsigned      entries;
    status_e          exp_status[$];
    logic [63:0]      exp_value[$];
    logic [CNT_W-1:0] exp_count[$];
    int unsigned      errors;
    int unsigned      requests;
    int unsigned      results;
    int unsigned      no_space_seen;

    function new();
      bucket_cfg = 9'd256;
      entries = 0;
      errors = 0;
      requests = 0;
      results = 0;
      no_space_seen = 0;
      foreach (head_v[i]) head_v[i] = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function void note_request(logic [1:0] op, logic [63:0] key_in, logic [3:0] len_in,
                               logic [63:0] val, logic allow);
      int unsigned len, n, b, cur, steps, f;
      bit [63:0] key, h;
      bit have, hit;
      int unsigned s;
      status_e st;
      logic [63:0] rd;
      len = (len_in > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len_in;
      key = key_in;
      if (len < 8) key &= (64'h1 << (8 * len)) - 64'h1;
      h = FNV_BASIS;
      for (int i = 0; i < len; i++) begin
        h ^= (key >> (8 * i)) & 64'hff;
        h *= 64'h100000001b3;
      end
      n = (bucket_cfg == 0) ? 1 : ((bucket_cfg > BUCKETS) ? BUCKETS : bucket_cfg);
      b = 32'(h % n);
      st = ST_NFOUND;
      rd = '0;
      hit = 0;
      s = 0;
      have = head_v[b];
      cur = head[b];
      steps = 0;
      while (have && steps < POOL_ENTRIES && !hit) begin
        if (slen[cur] == len && shash[cur] == h && skey[cur] == key) begin
          hit = 1;
          s = cur;
        end else begin
          have = nv[cur];
          cur = nxt[cur];
          steps++;
        end
      end
      requests++;
      case (op)
        OP_SET: begin
          if (hit) begin
            sval[s] = val;
            st = ST_OK;
          end else if (allow) begin
            f = POOL_ENTRIES;
            for (int i = POOL_ENTRIES - 1; i >= 0; i--) if (!used[i]) f = i;
            if (f == POOL_ENTRIES) begin
              st = ST_NOSPACE;
              no_space_seen++;
            end else begin
              used[f] = 1;
              skey[f] = key;
              slen[f] = 4'(len);
              shash[f] = h;
              sval[f] = val;
              pv[f] = 0;
              prv[f] = '0;
              nv[f] = head_v[b];
              nxt[f] = head[b];
              if (head_v[b]) begin
                prv[head[b]] = IDX_W'(f);
                pv[head[b]] = 1;
              end
              head[b] = IDX_W'(f);
              head_v[b] = 1;
              entries++;
              st = ST_OK;
            end
          end
        end
        OP_GET: begin
          if (hit) begin
            rd = sval[s];
            st = ST_OK;
          end
        end
        OP_REM: begin
          if (hit) begin
            if (pv[s]) begin
              nxt[prv[s]] = nxt[s];
              nv[prv[s]] = nv[s];
            end else begin
              head[b] = nxt[s];
              head_v[b] = nv[s];
            end
            if (nv[s]) begin
              prv[nxt[s]] = prv[s];
              pv[nxt[s]] = pv[s];
            end
            used[s] = 0;
            if (entries > 0) entries--;
            st = ST_OK;
          end
        end
        default: ;
      endcase
      exp_status.push_back(st);
      exp_value.push_back(rd);
      exp_count.push_back(entries[CNT_W-1:0]);
    endfunction

    function void check_result(logic [1:0] st, logic [63:0] rd, logic [CNT_W-1:0] cnt);
      status_e     e_st;
      logic [63:0] e_rd;
      logic [CNT_W-1:0] e_cnt;
      results++;
      if (exp_status.size() == 0) begin
        $error("result beat with nothing expected: status %0d", st);
        errors++;
        return;
      end
      e_st = exp_status.pop_front();
      e_rd = exp_value.pop_front();
      e_cnt = exp_count.pop_front();
      if (st !== e_st) begin
        $error("status: expected %0d, got %0d", e_st, st);
        errors++;
      end
      if (rd !== e_rd) begin
        $error("read_value: expected %h, got %h", e_rd, rd);
        errors++;
      end
      if (cnt !== e_cnt) begin
        $error("stored_count: expected %0d, got %0d", e_cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [BCFG_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        operation_i;
  logic [63:0]       key_bytes_i;
  logic [3:0]        key_length_i;
  logic [63:0]       new_value_i;
  logic              allow_insert_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [63:0]       read_value_o;
  logic [CNT_W-1:0]  stored_count_o;

  fnv1a_chained_hash_table_unit uut (.*);

  hash_table_scoreboard table_sb = new();

  bit          hold_req;
  int unsigned burst_left;
  int unsigned idle_cycles;
  logic [63:0] key_pool[$];
  logic [3:0]  len_pool[$];

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sender: one beat per call, opening a random gap when a burst runs out
  task automatic send_beat(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                           logic [63:0] val, logic allow);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    key_bytes_i    <= key;
    key_length_i   <= len;
    new_value_i    <= val;
    allow_insert_i <= allow;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    table_sb.note_request(op, key, len, val, allow);
  endtask

  task automatic write_buckets(logic [BCFG_W-1:0] v);
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (table_sb.exp_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_sb.bucket_cfg = v;
  endtask

  task automatic refill_keys(int unsigned count);
    key_pool.delete();
    len_pool.delete();
    repeat (count) begin
      key_pool.push_back({$urandom, $urandom});
      len_pool.push_back($urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 2))
                                                   : 4'($urandom_range(1, 8)));
    end
  endtask

  // fill_bias: percent of beats that are inserting sets
  task automatic random_phase(int unsigned beats, int unsigned fill_bias);
    int unsigned idx, roll;
    logic [63:0] key, junk, mask;
    logic [3:0]  len;
    logic [1:0]  op;
    repeat (beats) begin
      roll = $urandom_range(0, 99);
      idx = $urandom_range(0, key_pool.size() - 1);
      len = len_pool[idx];
      junk = {$urandom, $urandom};
      mask = (len >= 8) ? '1 : ((64'h1 << (8 * len)) - 64'h1);
      key = (key_pool[idx] & mask) | (junk & ~mask);
      if (len == 8 && $urandom_range(0, 3) == 0) len = 4'($urandom_range(8, 15));
      if (roll < fill_bias) op = OP_SET;
      else if (roll < 97) op = ($urandom_range(0, 2) == 0) ? OP_REM
                              : (($urandom_range(0, 1) == 0) ? OP_GET : OP_SET);
      else op = OP_NOP;
      if (roll >= 97 && $urandom_range(0, 1) == 0) begin
        key = {$urandom, $urandom};
        len = 4'($urandom_range(0, 15));
      end
      send_beat(op, key, len, {$urandom, $urandom},
                (roll < fill_bias) ? 1'b1 : 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver: out_ready follows a randomly drawn pattern (always, random, mostly not); long hold-off on request
  initial begin
    int unsigned mode, tick;
    out_ready_i = 1'b0;
    mode = 0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (tick % 64 == 0) mode = $urandom_range(0, 2);
      tick++;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      table_sb.check_result(status_o, read_value_o, stored_count_o);
  end

  // watchdog on cycles with no beat while work is pending
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && table_sb.exp_status.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] k8;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    operation_i = OP_SET;
    key_bytes_i = '0;
    key_length_i = '0;
    new_value_i = '0;
    allow_insert_i = 1'b0;
    hold_req = 0;
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, junk bits past the key, no-op
    k8 = 64'hffff_ffff_ffff_ffff;
    send_beat(OP_GET, k8, 4'd8, '0, 1'b0);
    send_beat(OP_SET, k8, 4'd8, 64'h1234, 1'b0);
    send_beat(OP_SET, k8, 4'd8, k8, 1'b1);
    send_beat(OP_SET, 64'h0, 4'd0, 64'h0, 1'b1);
    send_beat(OP_GET, 64'hdead_beef_0000_0000, 4'd0, '0, 1'b0);
    send_beat(OP_SET, 64'h0, 4'd8, 64'h55, 1'b1);
    send_beat(OP_GET, k8, 4'd15, '0, 1'b0);
    send_beat(OP_SET, 64'hffff_ff00_0000_00a5, 4'd1, 64'haaaa, 1'b1);
    send_beat(OP_GET, 64'h0000_0000_0000_00a5, 4'd1, '0, 1'b0);
    send_beat(OP_SET, 64'h1234_5678_0000_00a5, 4'd1, 64'hbbbb, 1'b0);
    send_beat(OP_GET, 64'h00a5, 4'd2, '0, 1'b0);
    send_beat(OP_NOP, k8, 4'd8, k8, 1'b1);
    send_beat(OP_REM, k8, 4'd9, '0, 1'b0);
    send_beat(OP_REM, k8, 4'd8, '0, 1'b0);
    send_beat(OP_GET, k8, 4'd8, '0, 1'b0);
    send_beat(OP_GET, 64'h00a5, 4'd1, '0, 1'b0);

    // one bucket: every key lands on a single chain; unlink middle, head, tail
    write_buckets(9'd1);
    for (int i = 1; i <= 5; i++) send_beat(OP_SET, 64'(i), 4'd3, 64'(i * 7), 1'b1);
    send_beat(OP_REM, 64'd3, 4'd3, '0, 1'b0);
    send_beat(OP_REM, 64'd5, 4'd3, '0, 1'b0);
    send_beat(OP_REM, 64'd1, 4'd3, '0, 1'b0);
    send_beat(OP_GET, 64'd2, 4'd3, '0, 1'b0);
    refill_keys(60);
    random_phase(250, 40);

    // out-of-range counts, then 7 and 256 again; the pool fills up and the receiver holds off once
    write_buckets(9'd0);
    random_phase(150, 40);
    write_buckets(9'd511);
    refill_keys(330);
    hold_req = 1;
    random_phase(500, 75);
    write_buckets(9'd7);
    random_phase(450, 15);
    write_buckets(9'd256);
    refill_keys(120);
    random_phase(470, 40);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (table_sb.exp_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d pool-full answers",
             table_sb.requests, table_sb.results, table_sb.no_space_seen);
    $display("bucket counts 256, 1, 0, 511, 7 and 256 again, with one long output hold-off");
    if (table_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fnvh_pkg.sv
hdl/fnvh_ram.sv
hdl/fnvh_hash.sv
hdl/fnv1a_chained_hash_table_unit.sv
test/tb_fnv1a_chained_hash_table_unit.sv
